// ----- sv/sbt_pkg.sv -----
// Shared types, constants and byte-class functions of the source byte tokenizer.
// Used by the front, queue, back and top-level modules. No dependencies.

package sbt_pkg;

  localparam int unsigned OFFSET_BITS_DEF   = 16;
  localparam int unsigned KEYWORD_CHARS_DEF = 6;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  localparam int unsigned KIND_BITS    = 6;
  localparam int unsigned POS_BITS     = 16;
  localparam int unsigned BYTE_BITS    = 8;
  localparam int unsigned KW_BUF_BITS  = 64;
  localparam int unsigned KW_COUNT     = 10;

  localparam logic [POS_BITS-1:0] LEN_MAX = '1;

  localparam logic [KIND_BITS-1:0] KIND_END     = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_IDENT   = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_STRING  = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_KW_BASE = 6'd4;
  localparam logic [KIND_BITS-1:0] KIND_EQ_EQ   = 6'd14;
  localparam logic [KIND_BITS-1:0] KIND_NOT_EQ  = 6'd15;
  localparam logic [KIND_BITS-1:0] KIND_GE      = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_LE      = 6'd17;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_GT      = 6'd19;
  localparam logic [KIND_BITS-1:0] KIND_LT      = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_PLUS    = 6'd21;
  localparam logic [KIND_BITS-1:0] KIND_MINUS   = 6'd22;
  localparam logic [KIND_BITS-1:0] KIND_STAR    = 6'd23;
  localparam logic [KIND_BITS-1:0] KIND_SLASH   = 6'd24;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 6'd25;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 6'd26;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 6'd27;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 6'd28;
  localparam logic [KIND_BITS-1:0] KIND_LBRACK  = 6'd29;
  localparam logic [KIND_BITS-1:0] KIND_RBRACK  = 6'd30;
  localparam logic [KIND_BITS-1:0] KIND_COMMA   = 6'd31;
  localparam logic [KIND_BITS-1:0] KIND_BAD     = 6'd32;
  localparam logic [KIND_BITS-1:0] KIND_UNTERM  = 6'd33;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keyword text packed with its first character in the lowest byte.
  localparam logic [KW_BUF_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0074_6E69_7270,  // print
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0065_6C69_6877,  // while
    64'h0000_0000_0072_6F66,  // for
    64'h0000_0000_0000_6E69,  // in
    64'h0000_0000_0000_6E66,  // fn
    64'h0000_6E72_7574_6572,  // return
    64'h0000_0000_6575_7274,  // true
    64'h0000_0065_736C_6166   // false
  };
  localparam logic [POS_BITS-1:0] KW_LEN [KW_COUNT] = '{
    16'd5, 16'd2, 16'd4, 16'd5, 16'd3, 16'd2, 16'd2, 16'd6, 16'd4, 16'd5
  };

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_IDENT  = 6'b000010,
    MODE_NUMBER = 6'b000100,
    MODE_STRING = 6'b001000,
    MODE_OP     = 6'b010000,
    MODE_ERROR  = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [POS_BITS-1:0]  start;
    logic [POS_BITS-1:0]  len;
    logic [BYTE_BITS-1:0] bad;
    logic                 sat;
  } tok_t;

  // A bundle holds the one or two tokens that one accepted byte yields.
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } bundle_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= CH_LO_A) && (b <= CH_LO_Z)) || ((b >= CH_UP_A) && (b <= CH_UP_Z)) ||
           (b == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] b);
    logic [KIND_BITS-1:0] k;
    case (b)
      CH_EQ:     k = KIND_ASSIGN;
      CH_GT:     k = KIND_GT;
      CH_LT:     k = KIND_LT;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_BITS-1:0] word_kind(input logic [KW_BUF_BITS-1:0] text,
                                                     input logic [POS_BITS-1:0] len);
    logic [KIND_BITS-1:0] k;
    k = KIND_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if ((len == KW_LEN[i]) && (text == KW_TEXT[i])) begin
        k = KIND_KW_BASE + KIND_BITS'(i);
      end
    end
    return k;
  endfunction

endpackage

// ----- sv/sbt_front.sv -----
// Front end of the source byte tokenizer: accepts bytes, tracks the scan state
// and pushes the tokens each byte produces (none, one or two) into the queue. Uses sbt_pkg.

module sbt_front #(
  parameter int unsigned OFFSET_BITS   = sbt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned KEYWORD_CHARS = sbt_pkg::KEYWORD_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  logic             q_full,
  output logic             q_push,
  output sbt_pkg::bundle_t q_data
);

  localparam int unsigned WORD_BITS = 8 * KEYWORD_CHARS;
  localparam int unsigned PB = sbt_pkg::POS_BITS;

  sbt_pkg::mode_t         mode_r, mode_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [WORD_BITS-1:0]   word_r, word_nxt;
  logic [PB-1:0]          len_r, len_nxt;
  logic                   sat_r, sat_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;

  logic                   accept;
  logic [7:0]             b;
  logic                   is_end;
  logic [OFFSET_BITS-1:0] off_inc;

  logic [WORD_BITS-1:0]   grow_word;
  logic [PB-1:0]          grow_len;
  logic                   grow_sat;

  sbt_pkg::tok_t          run_tok;
  sbt_pkg::tok_t          flush_tok;
  logic                   flush_has;
  sbt_pkg::mode_t         flush_mode;

  sbt_pkg::tok_t          fresh_tok;
  logic                   fresh_has;
  logic                   fresh_run;
  logic                   fresh_err;
  sbt_pkg::mode_t         fresh_mode;
  logic [OFFSET_BITS-1:0] fresh_start;
  logic [PB-1:0]          fresh_len;
  logic [WORD_BITS-1:0]   fresh_word;
  logic [7:0]             fresh_pend;

  sbt_pkg::tok_t          tok_a, tok_b;
  logic                   has_a, has_b;
  logic                   use_flush, use_fresh;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign is_end    = in_tlast || (b == 8'h00);
  assign off_inc   = offset_r + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    grow_word = word_r;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (len_r == PB'(i)) begin
        grow_word[8*i +: 8] = b;
      end
    end
    if (len_r != sbt_pkg::LEN_MAX) begin
      grow_len = len_r + 16'd1;
      grow_sat = sat_r;
    end else begin
      grow_len = len_r;
      grow_sat = 1'b1;
    end
  end

  always_comb begin
    run_tok.kind  = sbt_pkg::KIND_IDENT;
    run_tok.start = PB'(start_r);
    run_tok.len   = len_r;
    run_tok.bad   = '0;
    run_tok.sat   = sat_r;

    flush_tok  = run_tok;
    flush_has  = 1'b0;
    flush_mode = mode_r;
    case (mode_r)
      sbt_pkg::MODE_IDENT: begin
        flush_tok.kind = sbt_pkg::word_kind(sbt_pkg::KW_BUF_BITS'(word_r), len_r);
        flush_has      = 1'b1;
        flush_mode     = sbt_pkg::MODE_IDLE;
      end
      sbt_pkg::MODE_NUMBER: begin
        flush_tok.kind = sbt_pkg::KIND_NUMBER;
        flush_has      = 1'b1;
        flush_mode     = sbt_pkg::MODE_IDLE;
      end
      sbt_pkg::MODE_OP: begin
        flush_has     = 1'b1;
        flush_tok.len = 16'd1;
        flush_tok.sat = 1'b0;
        if (pend_r == sbt_pkg::CH_BANG) begin
          flush_tok.kind = sbt_pkg::KIND_BAD;
          flush_tok.bad  = sbt_pkg::CH_BANG;
          flush_mode     = sbt_pkg::MODE_ERROR;
        end else begin
          flush_tok.kind = sbt_pkg::single_kind(pend_r);
          flush_mode     = sbt_pkg::MODE_IDLE;
        end
      end
      default: begin
        flush_has = 1'b0;
      end
    endcase
  end

  always_comb begin
    fresh_tok.kind  = sbt_pkg::single_kind(b);
    fresh_tok.start = PB'(offset_r);
    fresh_tok.len   = 16'd1;
    fresh_tok.bad   = '0;
    fresh_tok.sat   = 1'b0;
    fresh_has   = 1'b0;
    fresh_run   = 1'b0;
    fresh_err   = 1'b0;
    fresh_mode  = sbt_pkg::MODE_IDLE;
    fresh_start = offset_r;
    fresh_len   = '0;
    fresh_word  = '0;
    fresh_pend  = '0;
    if (sbt_pkg::is_space(b)) begin
      fresh_has = 1'b0;
    end else if (b == sbt_pkg::CH_QUOTE) begin
      fresh_run   = 1'b1;
      fresh_mode  = sbt_pkg::MODE_STRING;
      fresh_start = off_inc;
    end else if (sbt_pkg::is_alpha(b) || sbt_pkg::is_digit(b)) begin
      fresh_run  = 1'b1;
      fresh_mode = sbt_pkg::is_alpha(b) ? sbt_pkg::MODE_IDENT : sbt_pkg::MODE_NUMBER;
      fresh_len  = 16'd1;
      fresh_word = WORD_BITS'(b);
    end else if ((b == sbt_pkg::CH_EQ) || (b == sbt_pkg::CH_BANG) ||
                 (b == sbt_pkg::CH_GT) || (b == sbt_pkg::CH_LT)) begin
      fresh_run  = 1'b1;
      fresh_mode = sbt_pkg::MODE_OP;
      fresh_pend = b;
    end else if (fresh_tok.kind != sbt_pkg::KIND_END) begin
      fresh_has = 1'b1;
    end else begin
      fresh_has      = 1'b1;
      fresh_err      = 1'b1;
      fresh_tok.kind = sbt_pkg::KIND_BAD;
      fresh_tok.bad  = b;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    word_nxt   = word_r;
    len_nxt    = len_r;
    sat_nxt    = sat_r;
    start_nxt  = start_r;
    offset_nxt = off_inc;
    use_flush  = 1'b0;
    use_fresh  = 1'b0;
    tok_a      = run_tok;
    tok_b      = fresh_tok;
    has_a      = 1'b0;
    has_b      = 1'b0;

    if (is_end) begin
      if (mode_r == sbt_pkg::MODE_STRING) begin
        tok_a.kind = sbt_pkg::KIND_UNTERM;
        has_a      = 1'b1;
      end else begin
        tok_a = flush_tok;
        has_a = flush_has;
      end
      tok_b.kind  = sbt_pkg::KIND_END;
      tok_b.start = PB'(offset_r);
      tok_b.len   = '0;
      tok_b.bad   = '0;
      tok_b.sat   = 1'b0;
      has_b       = 1'b1;
      mode_nxt    = sbt_pkg::MODE_IDLE;
      pend_nxt    = '0;
      word_nxt    = '0;
      len_nxt     = '0;
      sat_nxt     = 1'b0;
      start_nxt   = '0;
      offset_nxt  = '0;
    end else begin
      case (mode_r)
        sbt_pkg::MODE_STRING: begin
          if (b == sbt_pkg::CH_QUOTE) begin
            tok_a.kind = sbt_pkg::KIND_STRING;
            has_a      = 1'b1;
            mode_nxt   = sbt_pkg::MODE_IDLE;
          end else begin
            word_nxt = grow_word;
            len_nxt  = grow_len;
            sat_nxt  = grow_sat;
          end
        end
        sbt_pkg::MODE_IDENT, sbt_pkg::MODE_NUMBER: begin
          if (sbt_pkg::is_digit(b) ||
              (sbt_pkg::is_alpha(b) && (mode_r == sbt_pkg::MODE_IDENT))) begin
            word_nxt = grow_word;
            len_nxt  = grow_len;
            sat_nxt  = grow_sat;
          end else begin
            use_flush = 1'b1;
            use_fresh = 1'b1;
          end
        end
        sbt_pkg::MODE_OP: begin
          if (b == sbt_pkg::CH_EQ) begin
            tok_a.len = 16'd2;
            tok_a.sat = 1'b0;
            case (pend_r)
              sbt_pkg::CH_EQ:   tok_a.kind = sbt_pkg::KIND_EQ_EQ;
              sbt_pkg::CH_BANG: tok_a.kind = sbt_pkg::KIND_NOT_EQ;
              sbt_pkg::CH_GT:   tok_a.kind = sbt_pkg::KIND_GE;
              default:          tok_a.kind = sbt_pkg::KIND_LE;
            endcase
            has_a    = 1'b1;
            pend_nxt = '0;
            mode_nxt = sbt_pkg::MODE_IDLE;
          end else begin
            use_flush = 1'b1;
            use_fresh = (pend_r != sbt_pkg::CH_BANG);
          end
        end
        sbt_pkg::MODE_IDLE: begin
          use_fresh = 1'b1;
        end
        default: begin
          mode_nxt = sbt_pkg::MODE_ERROR;
        end
      endcase

      if (use_flush) begin
        tok_a    = flush_tok;
        has_a    = flush_has;
        mode_nxt = flush_mode;
        if (mode_r == sbt_pkg::MODE_OP) begin
          pend_nxt = '0;
        end
      end
      if (use_fresh) begin
        has_b = fresh_has;
        if (fresh_run) begin
          mode_nxt  = fresh_mode;
          start_nxt = fresh_start;
          len_nxt   = fresh_len;
          sat_nxt   = 1'b0;
          word_nxt  = fresh_word;
          if (fresh_mode == sbt_pkg::MODE_OP) begin
            pend_nxt = fresh_pend;
          end
        end else if (fresh_err) begin
          mode_nxt = sbt_pkg::MODE_ERROR;
        end
      end
    end
  end

  assign q_push        = accept && (has_a || has_b);
  assign q_data.tok0   = has_a ? tok_a : tok_b;
  assign q_data.tok1   = tok_b;
  assign q_data.two    = has_a && has_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sbt_pkg::MODE_IDLE;
      pend_r   <= '0;
      word_r   <= '0;
      len_r    <= '0;
      sat_r    <= 1'b0;
      start_r  <= '0;
      offset_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      word_r   <= word_nxt;
      len_r    <= len_nxt;
      sat_r    <= sat_nxt;
      start_r  <= start_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

// ----- sv/sbt_queue.sv -----
// Token bundle queue between the front and back ends of the source byte tokenizer.
// Register-based FIFO; its depth must be a power of two (not enforced). Uses sbt_pkg.

module sbt_queue #(
  parameter int unsigned DEPTH = sbt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sbt_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output sbt_pkg::bundle_t pop_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sbt_pkg::bundle_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + {{(PW-1){1'b0}}, 1'b1} : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + {{(PW-1){1'b0}}, 1'b1} : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + {{(CW-1){1'b0}}, 1'b1};
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - {{(CW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- sv/sbt_back.sv -----
// Back end of the source byte tokenizer: splits queued bundles into single tokens
// and holds each in the output register until it is taken. Uses sbt_pkg.

module sbt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  sbt_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,
  output logic [6:0]       out_tuser,
  output logic             out_tlast
);

  logic          valid_r, valid_nxt;
  logic          sel_r, sel_nxt;
  sbt_pkg::tok_t tok_r, tok_nxt;
  logic          last_r, last_nxt;
  logic          load;

  assign load = (!valid_r || out_tready) && !q_empty;

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    tok_nxt   = tok_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (!valid_r || out_tready) begin
      valid_nxt = !q_empty;
    end
    if (load) begin
      tok_nxt = sel_r ? q_data.tok1 : q_data.tok0;
      if (q_data.two && !sel_r) begin
        sel_nxt  = 1'b1;
        last_nxt = 1'b0;
      end else begin
        sel_nxt  = 1'b0;
        last_nxt = 1'b1;
        q_pop    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {tok_r.bad, tok_r.len, tok_r.start};
  assign out_tuser  = {tok_r.sat, tok_r.kind};
  assign out_tlast  = last_r;

endmodule

// ----- sv/source_byte_tokenizer.sv -----
// Top level of the source byte tokenizer: front end, bundle queue and back end.
// Depends on sbt_pkg, sbt_front, sbt_queue and sbt_back.
//
//   Channel   Direction  Ports                   Transaction
//   in_       input      tvalid tready tdata tlast  one source byte, tlast ends source
//   out_      output     tvalid tready tdata tuser tlast  one token, tlast on last of byte
//
// A byte is taken every cycle while the queue has room; each byte gives zero, one or
// two tokens, and the back end sends one token per cycle from its output register
// while out_tready is high. A token passes through a queue entry and then that register.
// Reset clears the scan state, the offset, the queue pointers and count, and the output valid flag.
// A stalled output fills the QUEUE_DEPTH-entry queue, and then in_tready drops.

module source_byte_tokenizer #(
  parameter int unsigned OFFSET_BITS   = sbt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned KEYWORD_CHARS = sbt_pkg::KEYWORD_CHARS_DEF,
  parameter int unsigned QUEUE_DEPTH   = sbt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] start_offset, [31:16] token_length, [39:32] bad_byte
  output logic [6:0]  out_tuser,  // [5:0] kind, [6] too_long
  output logic        out_tlast
);

  logic             q_push, q_full, q_pop, q_empty;
  sbt_pkg::bundle_t q_in, q_out;

  sbt_front #(
    .OFFSET_BITS  (OFFSET_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  sbt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  sbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
